FILE: design/scfc_pkg.sv
// Package for the scope frame CRC-16 framer: shared types, frame constants and
// the CRC-16/MODBUS linear-map helpers that the lanes evaluate at elaboration.
// Used by the framer top, lane and merge files; it depends on nothing.
package scfc_pkg;

	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned FRAME_W = FRAME_LEN * BYTE_W;
	localparam int unsigned IDX_W = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WORD_W-1:0][WORD_W-1:0] crc_mat_t;
	typedef logic [NUM_LANES-1:0][WORD_W-1:0] lane_words_t;

	// One bit step of the reflected CRC register with no data input.
	function automatic word_t crc_bit_step(input word_t crc);
		word_t shifted;
		shifted = crc >> 1;
		return crc[0] ? (shifted ^ CRC_POLY) : shifted;
	endfunction

	// Runs the CRC register through a number of whole 16-bit words of zeros.
	// Only evaluated on constants at elaboration.
	function automatic word_t crc_shift_words(input word_t crc, input int unsigned words);
		word_t acc;
		acc = crc;
		for (int unsigned k = 0; k < words * WORD_W; k++) begin
			acc = crc_bit_step(acc);
		end
		return acc;
	endfunction

	// Column i of the matrix is the image of a single set bit i under the map.
	function automatic crc_mat_t crc_shift_matrix(input int unsigned words);
		crc_mat_t mat;
		for (int unsigned i = 0; i < WORD_W; i++) begin
			mat[i] = crc_shift_words(word_t'(1) << i, words);
		end
		return mat;
	endfunction

	// Applies a constant matrix to a word: an XOR of the selected columns.
	function automatic word_t crc_apply(input crc_mat_t mat, input word_t w);
		word_t acc;
		acc = '0;
		for (int unsigned i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				acc = acc ^ mat[i];
			end
		end
		return acc;
	endfunction

	// Contribution of the initial value after all four data words.
	localparam word_t CRC_SEED_TERM = crc_shift_words(CRC_INIT, NUM_LANES);

endpackage

FILE: design/scfc_if.sv
// Channel interfaces of the scope frame CRC-16 framer: the four-channel
// record channel and the byte-wide frame channel, both valid/ready.
// Depends on nothing; widths are fixed by the frame format.
interface scfc_rec_if;
	logic valid;
	logic ready;
	logic [15:0] channel_0;
	logic [15:0] channel_1;
	logic [15:0] channel_2;
	logic [15:0] channel_3;

	modport source(output valid, output channel_0, output channel_1,
		output channel_2, output channel_3, input ready);
	modport sink(input valid, input channel_0, input channel_1,
		input channel_2, input channel_3, output ready);
endinterface

interface scfc_byte_if;
	logic valid;
	logic ready;
	logic [7:0] frame_byte;
	logic last_byte;

	modport source(output valid, output frame_byte, output last_byte, input ready);
	modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

FILE: design/scope_frame_crc16_framer.sv
// Scope frame CRC-16 framer: turns a record of four 16-bit channel values into
// a ten-byte frame closed by a CRC-16/MODBUS.
//
// Channels: samples (sink) takes one record per transaction with channel_0 to
// channel_3. frame (source) gives one byte per transaction: the channels in
// order, each low byte then high byte, then the CRC low byte and the CRC high
// byte, the last one marked by last_byte.
// Path: an accepted record is held by the lane registers and moves into the
// serializer register once it is free; the first byte of its frame then shows.
// Pacing: set by the byte-wide frame channel; the next record waits in the lane
// registers while a frame is sent, so a new record is taken while the previous
// frame still goes out.
// Four lanes each compute the CRC contribution of one channel word; the merge
// stage XORs them combinationally with a constant seed term.
// Reset clears the lane and serializer valid flags; no frame is shown.
// When the receiver stalls, the current byte holds, the lane registers hold
// one waiting record, and samples.ready drops once both are occupied.
module scope_frame_crc16_framer (
	input  logic        clk,
	input  logic        arst_n,
	scfc_rec_if.sink    samples,
	scfc_byte_if.source frame
);

	logic s1_valid_q;
	logic accept;
	logic free;
	logic load;
	scfc_pkg::lane_words_t words;
	scfc_pkg::lane_words_t words_s1;
	scfc_pkg::lane_words_t contribs_s1;

	assign words[0] = samples.channel_0;
	assign words[1] = samples.channel_1;
	assign words[2] = samples.channel_2;
	assign words[3] = samples.channel_3;

	assign load = s1_valid_q && free;
	assign samples.ready = !s1_valid_q || free;
	assign accept = samples.valid && samples.ready;

	// Lane stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (load) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Lane i pushes its word through its own place and the words that follow it in the frame.
	for (genvar i = 0; i < scfc_pkg::NUM_LANES; i++) begin : g_lane
		scfc_lane #(
			.SHIFT_WORDS(scfc_pkg::NUM_LANES - i)
		) u_lane (
			.clk(clk),
			.load(accept),
			.word(words[i]),
			.word_s1(words_s1[i]),
			.contrib_s1(contribs_s1[i])
		);
	end

	scfc_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.words_s1(words_s1),
		.contribs_s1(contribs_s1),
		.free(free),
		.frame(frame)
	);

	// An accepted record always occupies the lane stage in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted record not held in lane stage");

	// A frame that finishes with nothing waiting leaves the output idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready && frame.last_byte && !load |=> !frame.valid)
		else $error("frame output stays valid after last byte");

	// Loading the serializer always shows a first byte in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> frame.valid && !frame.last_byte)
		else $error("loaded frame does not start with its first byte");

endmodule

FILE: design/scfc_lane.sv
// One CRC lane of the scope frame CRC-16 framer: registers one channel word
// and its CRC contribution, pushed through its own word and those that follow it.
// Depends on scfc_pkg.
module scfc_lane #(
	parameter int unsigned SHIFT_WORDS = 1
) (
	input  logic                clk,
	input  logic                load,
	input  scfc_pkg::word_t     word,
	output scfc_pkg::word_t     word_s1,
	output scfc_pkg::word_t     contrib_s1
);

	localparam scfc_pkg::crc_mat_t LANE_MAT = scfc_pkg::crc_shift_matrix(SHIFT_WORDS);

	// The word and its contribution are captured together on each accepted transaction.
	always_ff @(posedge clk) begin
		if (load) begin
			word_s1 <= word;
			contrib_s1 <= scfc_pkg::crc_apply(LANE_MAT, word);
		end
	end

endmodule

FILE: design/scfc_merge.sv
// Merging and serializing stage of the scope frame CRC-16 framer: combines the
// lane contributions into the CRC and sends the ten-byte frame one byte a cycle
// while the receiver is ready. Depends on scfc_pkg and scfc_if.
module scfc_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  scfc_pkg::lane_words_t   words_s1,
	input  scfc_pkg::lane_words_t   contribs_s1,
	output logic                    free,
	scfc_byte_if.source             frame
);

	logic [scfc_pkg::FRAME_W-1:0] frame_q;
	logic [scfc_pkg::IDX_W-1:0] byte_idx_q;
	logic tx_valid_q;
	scfc_pkg::word_t crc;
	logic byte_done;
	logic frame_done;

	// The CRC is the seed term XORed with every lane contribution.
	always_comb begin
		crc = scfc_pkg::CRC_SEED_TERM;
		for (int unsigned i = 0; i < scfc_pkg::NUM_LANES; i++) begin
			crc = crc ^ contribs_s1[i];
		end
	end

	assign byte_done = tx_valid_q && frame.ready;
	assign frame_done = byte_done && (byte_idx_q == scfc_pkg::LAST_IDX);
	assign free = !tx_valid_q || frame_done;

	// Control: a frame is in flight until its last byte transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
			byte_idx_q <= '0;
		end else if (load) begin
			tx_valid_q <= 1'b1;
			byte_idx_q <= '0;
		end else if (frame_done) begin
			tx_valid_q <= 1'b0;
			byte_idx_q <= '0;
		end else if (byte_done) begin
			byte_idx_q <= byte_idx_q + 1'b1;
		end
	end

	// Frame shift register, channel 0 low byte in the bottom byte.
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= {crc, words_s1[3], words_s1[2], words_s1[1], words_s1[0]};
		end else if (byte_done) begin
			frame_q <= frame_q >> scfc_pkg::BYTE_W;
		end
	end

	assign frame.valid = tx_valid_q;
	assign frame.frame_byte = frame_q[scfc_pkg::BYTE_W-1:0];
	assign frame.last_byte = (byte_idx_q == scfc_pkg::LAST_IDX);

endmodule
